### rtl/ple_pkg.sv
// package for the positional list engine: sizes, codes and item types
package ple_pkg;

  // list geometry
  localparam int CAPACITY   = 16;
  localparam int WORD_BITS  = 32;
  localparam int POS_BITS   = 5;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CMP_BITS   = ((POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS) + 1;

  // request modes
  localparam logic [1:0] MODE_APPEND   = 2'd0;
  localparam logic [1:0] MODE_INSERT   = 2'd1;
  localparam logic [1:0] MODE_REMOVE   = 2'd2;
  localparam logic [1:0] MODE_RETRIEVE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // request item
  typedef struct packed {
    logic [1:0]           mode;
    logic [POS_BITS-1:0]  position;
    logic [WORD_BITS-1:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [WORD_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0] item_count;
    logic [1:0]            status;
    logic                  is_empty;
  } out_item_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                 shift_up;
    logic                 shift_down;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  idx;
    logic [WORD_BITS-1:0] value;
  } cell_cmd_t;

endpackage

### rtl/ple_cell.sv
// one storage cell of the list row: holds a word, shifts with its neighbors
module ple_cell (
  input  logic                          clk,
  input  logic [ple_pkg::IDX_BITS-1:0]  cell_index,
  input  ple_pkg::cell_cmd_t            cmd,
  input  logic [ple_pkg::WORD_BITS-1:0] left_word,
  input  logic [ple_pkg::WORD_BITS-1:0] right_word,
  output logic [ple_pkg::WORD_BITS-1:0] word,
  output logic [ple_pkg::WORD_BITS-1:0] rd_word
);

  logic                          at_idx;
  logic                          above_idx;
  logic [ple_pkg::WORD_BITS-1:0] word_next;

  // position of this cell relative to the target
  assign at_idx    = (cell_index == cmd.idx);
  assign above_idx = (cell_index > cmd.idx);

  // next word: load, take from the left, take from the right or hold
  always_comb begin
    word_next = word;
    if (cmd.shift_up) begin
      if (at_idx) begin
        word_next = cmd.value;
      end else if (above_idx) begin
        word_next = left_word;
      end
    end else if (cmd.shift_down) begin
      if (at_idx || above_idx) begin
        word_next = right_word;
      end
    end
  end

  // word storage, contents undefined until written
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // read contribution, zero unless this cell is addressed
  assign rd_word = (cmd.rd_en && at_idx) ? word : '0;

endmodule

### rtl/ple_ctrl.sv
// request decode, position checks and word count for the list engine
module ple_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  ple_pkg::in_item_t  req,
  output ple_pkg::cell_cmd_t cmd,
  output ple_pkg::out_item_t result
);

  logic [ple_pkg::COUNT_BITS-1:0] word_count;
  logic [ple_pkg::COUNT_BITS-1:0] word_count_next;
  logic [ple_pkg::CMP_BITS-1:0]   pos_w;
  logic [ple_pkg::CMP_BITS-1:0]   count_w;
  logic [ple_pkg::IDX_BITS-1:0]   pos_m1;
  logic                           full;
  logic                           pos_ok_ins;
  logic                           pos_ok_sel;
  logic [1:0]                     status;

  // widened operands for the range checks
  assign pos_w      = ple_pkg::CMP_BITS'(req.position);
  assign count_w    = ple_pkg::CMP_BITS'(word_count);
  assign pos_m1     = ple_pkg::IDX_BITS'(req.position - ple_pkg::POS_BITS'(1));
  assign full       = (word_count == ple_pkg::COUNT_BITS'(ple_pkg::CAPACITY));
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= count_w + ple_pkg::CMP_BITS'(1));
  assign pos_ok_sel = (pos_w != '0) && (pos_w <= count_w);

  // decode: append is an insert just past the last word
  always_comb begin
    cmd             = '0;
    cmd.value       = req.value;
    cmd.idx         = pos_m1;
    status          = ple_pkg::ST_DONE;
    word_count_next = word_count;
    unique case (req.mode)
      ple_pkg::MODE_APPEND: begin
        cmd.idx = word_count[ple_pkg::IDX_BITS-1:0];
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          cmd.shift_up    = accept;
          word_count_next = word_count + ple_pkg::COUNT_BITS'(1);
        end
      end
      ple_pkg::MODE_INSERT: begin
        if (!pos_ok_ins) begin
          status = ple_pkg::ST_BADPOS;
        end else if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          cmd.shift_up    = accept;
          word_count_next = word_count + ple_pkg::COUNT_BITS'(1);
        end
      end
      ple_pkg::MODE_REMOVE: begin
        if (!pos_ok_sel) begin
          status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.shift_down  = accept;
          word_count_next = word_count - ple_pkg::COUNT_BITS'(1);
        end
      end
      ple_pkg::MODE_RETRIEVE: begin
        if (!pos_ok_sel) begin
          status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      default: begin
        status = ple_pkg::ST_BADPOS;
      end
    endcase
  end

  // result fields apart from the read word, which the cells supply
  always_comb begin
    result            = '0;
    result.item_count = word_count_next;
    result.status     = status;
    result.is_empty   = (word_count_next == '0);
  end

  // word count register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (accept) begin
      word_count <= word_count_next;
    end
  end

endmodule

### rtl/positional_list_engine.sv
// positional list engine top level: cell row, control and output buffer
// a result item is registered at out, or in the skid stage while out is stalled
// throughput: one item per cycle while not stalled; the whole row shifts in one step
// a two-deep output buffer lets one more item in while a result is stalled
// reset clears the word count and the output valids; stored words are undefined
// until written, so no clearing pass is needed
module positional_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_item_t out_item
);

  logic                          accept;
  ple_pkg::cell_cmd_t            cmd;
  ple_pkg::out_item_t            ctrl_result;
  ple_pkg::out_item_t            result;
  ple_pkg::out_item_t            skid_item;
  logic                          skid_valid;
  logic [ple_pkg::WORD_BITS-1:0] words   [ple_pkg::CAPACITY];
  logic [ple_pkg::WORD_BITS-1:0] rd_words[ple_pkg::CAPACITY];
  logic [ple_pkg::WORD_BITS-1:0] rd_any;

  // input handshake
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  // decode and count
  ple_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (in_item),
    .cmd    (cmd),
    .result (ctrl_result)
  );

  // row of cells, each wired to its neighbors
  for (genvar g = 0; g < ple_pkg::CAPACITY; g++) begin : g_cell
    logic [ple_pkg::WORD_BITS-1:0] left_word;
    logic [ple_pkg::WORD_BITS-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_left
      assign left_word = words[g-1];
    end

    if (g == ple_pkg::CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_right
      assign right_word = words[g+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .cell_index (ple_pkg::IDX_BITS'(g)),
      .cmd        (cmd),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[g]),
      .rd_word    (rd_words[g])
    );
  end

  // merge the read contributions, at most one is nonzero
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
      rd_any = rd_any | rd_words[i];
    end
  end

  always_comb begin
    result            = ctrl_result;
    result.read_value = rd_any;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_item  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_item  <= result;
      skid_valid <= 1'b1;
    end
  end

  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid item held with output empty");

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.item_count <= ple_pkg::COUNT_BITS'(ple_pkg::CAPACITY)))
    else $error("item count above capacity");

  // a full status is only reported on a full list
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status == ple_pkg::ST_FULL))
      |-> (out_item.item_count == ple_pkg::COUNT_BITS'(ple_pkg::CAPACITY)))
    else $error("full status with room left");

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.is_empty == (out_item.item_count == '0)))
    else $error("empty flag disagrees with count");

endmodule

### verif/positional_list_engine_checker.sv
// result checker for the positional list engine: tracks the list and compares each result item
module positional_list_engine_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ple_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ple_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending,
  output int                 list_len,
  output int                 checked,
  output int                 full_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the list and the results still owed by the block
  logic [ple_pkg::WORD_BITS-1:0] shadow_words [ple_pkg::CAPACITY];
  int                            shadow_len;
  ple_pkg::out_item_t            awaited_results [$];

  // apply one request to the shadow list and work out its result item
  task automatic apply_request(input ple_pkg::in_item_t req, output ple_pkg::out_item_t res);
    int i;
    int p;
    p = int'(req.position);
    res = '0;
    res.status = ple_pkg::ST_DONE;
    case (req.mode)
      ple_pkg::MODE_APPEND: begin
        if (shadow_len >= ple_pkg::CAPACITY) begin
          res.status = ple_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_len] = req.value;
          shadow_len++;
        end
      end
      ple_pkg::MODE_INSERT: begin
        // position is checked before capacity
        if (p < 1 || p > shadow_len + 1) begin
          res.status = ple_pkg::ST_BADPOS;
        end else if (shadow_len >= ple_pkg::CAPACITY) begin
          res.status = ple_pkg::ST_FULL;
        end else begin
          for (i = shadow_len; i >= p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p-1] = req.value;
          shadow_len++;
        end
      end
      ple_pkg::MODE_REMOVE: begin
        if (p < 1 || p > shadow_len) begin
          res.status = ple_pkg::ST_BADPOS;
        end else begin
          for (i = p; i < shadow_len; i++) shadow_words[i-1] = shadow_words[i];
          shadow_len--;
        end
      end
      default: begin
        // retrieve
        if (p < 1 || p > shadow_len) res.status = ple_pkg::ST_BADPOS;
        else res.read_value = shadow_words[p-1];
      end
    endcase
    res.item_count = ple_pkg::COUNT_BITS'(shadow_len);
    res.is_empty   = (shadow_len == 0);
  endtask

  // one field of a result item against its prediction
  task automatic check_field(input string field,
                             input logic [ple_pkg::WORD_BITS-1:0] want_v,
                             input logic [ple_pkg::WORD_BITS-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    ple_pkg::out_item_t want;
    ple_pkg::out_item_t reply;
    if (rst) begin
      shadow_len = 0;
      awaited_results.delete();
    end else begin
      // results first; a request never yields its item in the cycle it is taken
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual %h", $time, out_item);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("read_value", want.read_value, out_item.read_value);
          check_field("item_count", ple_pkg::WORD_BITS'(want.item_count),
                      ple_pkg::WORD_BITS'(out_item.item_count));
          check_field("status", ple_pkg::WORD_BITS'(want.status),
                      ple_pkg::WORD_BITS'(out_item.status));
          check_field("is_empty", ple_pkg::WORD_BITS'(want.is_empty),
                      ple_pkg::WORD_BITS'(out_item.is_empty));
          if (want.status == ple_pkg::ST_FULL) full_rejects++;
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_item, reply);
        awaited_results.push_back(reply);
      end
    end
    pending  = awaited_results.size();
    list_len = shadow_len;
  end

endmodule

### verif/positional_list_engine_test.sv
// testbench top for the positional list engine: clock, reset, request stimulus and verdict
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD      = 5;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_PER_PHASE = 524;
  localparam int QUIET_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 20;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ple_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ple_pkg::out_item_t out_item;

  logic in_taken       = 1'b0;
  int   send_gap_pct   = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles   = 0;
  int   sent           = 0;
  int   directed       = 0;
  int   fail_count;
  int   pending;
  int   list_len;
  int   checked;
  int   full_rejects;

  // idle percentages per phase: sender, then receiver
  int gap_pct   [3] = '{6, 50, 0};
  int stall_pct [3] = '{50, 6, 0};

  positional_list_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  positional_list_engine_checker list_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending      (pending),
    .list_len     (list_len),
    .checked      (checked),
    .full_rejects (full_rejects)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // acceptance flag for the sender, read at the next falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // cycles without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("positional_list_engine_test: errors");
    $finish;
  end

  function automatic ple_pkg::in_item_t make_request(input logic [1:0] mode,
                                                     input int position,
                                                     input logic [ple_pkg::WORD_BITS-1:0] value);
    ple_pkg::in_item_t r;
    r.mode     = mode;
    r.position = ple_pkg::POS_BITS'(position);
    r.value    = value;
    return r;
  endfunction

  // data words with the all-zero and all-one extremes mixed in
  function automatic logic [ple_pkg::WORD_BITS-1:0] pick_word();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ple_pkg::WORD_BITS'($urandom);
  endfunction

  // mostly well-aimed requests that drift the list up or down, some noise
  function automatic ple_pkg::in_item_t pick_request(input int len, input bit grow);
    int         roll;
    int         position;
    logic [1:0] mode;
    roll = $urandom_range(99);
    if (roll < 10) return make_request(2'($urandom_range(3)), $urandom_range(31), pick_word());
    roll = $urandom_range(99);
    if (grow) begin
      mode = (roll < 35) ? ple_pkg::MODE_APPEND : (roll < 70) ? ple_pkg::MODE_INSERT :
             (roll < 85) ? ple_pkg::MODE_REMOVE : ple_pkg::MODE_RETRIEVE;
    end else begin
      mode = (roll < 10) ? ple_pkg::MODE_APPEND : (roll < 20) ? ple_pkg::MODE_INSERT :
             (roll < 65) ? ple_pkg::MODE_REMOVE : ple_pkg::MODE_RETRIEVE;
    end
    case (mode)
      ple_pkg::MODE_APPEND: position = $urandom_range(31);
      ple_pkg::MODE_INSERT: position = $urandom_range(len + 1, 1);
      default:              position = (len == 0) ? 1 : $urandom_range(len, 1);
    endcase
    return make_request(mode, position, pick_word());
  endfunction

  // present one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_request(input ple_pkg::in_item_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_taken);
    sent++;
  endtask

  initial begin
    int phase;
    int n;
    bit grow;
    grow           = 1'b1;
    send_gap_pct   = gap_pct[0];
    recv_stall_pct = stall_pct[0];
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // rejects on an empty list
    send_request(make_request(ple_pkg::MODE_RETRIEVE, 1, '0));
    send_request(make_request(ple_pkg::MODE_REMOVE, 1, '1));
    send_request(make_request(ple_pkg::MODE_INSERT, 0, '1));
    send_request(make_request(ple_pkg::MODE_INSERT, 2, '1));
    // insert at the head, append, insert in the middle
    send_request(make_request(ple_pkg::MODE_INSERT, 1, '1));
    send_request(make_request(ple_pkg::MODE_APPEND, 31, '0));
    send_request(make_request(ple_pkg::MODE_INSERT, 2, 32'h5555_5555));
    // fill up, last word inserted at the tail
    while (list_len < ple_pkg::CAPACITY - 1) begin
      send_request(make_request(ple_pkg::MODE_APPEND, 0, pick_word()));
    end
    send_request(make_request(ple_pkg::MODE_INSERT, ple_pkg::CAPACITY, 32'haaaa_aaaa));
    // full list: append and insert rejected, bad position wins over full
    send_request(make_request(ple_pkg::MODE_APPEND, 0, '1));
    send_request(make_request(ple_pkg::MODE_INSERT, 1, '1));
    send_request(make_request(ple_pkg::MODE_INSERT, ple_pkg::CAPACITY + 2, '1));
    // reads at the last word and past both ends
    send_request(make_request(ple_pkg::MODE_RETRIEVE, ple_pkg::CAPACITY, '0));
    send_request(make_request(ple_pkg::MODE_RETRIEVE, ple_pkg::CAPACITY + 1, '0));
    send_request(make_request(ple_pkg::MODE_RETRIEVE, 0, '0));
    // remove last, first, middle and out of range
    send_request(make_request(ple_pkg::MODE_REMOVE, ple_pkg::CAPACITY, '0));
    send_request(make_request(ple_pkg::MODE_REMOVE, 1, '0));
    send_request(make_request(ple_pkg::MODE_REMOVE, 7, '0));
    send_request(make_request(ple_pkg::MODE_REMOVE, 31, '0));
    directed = sent;

    // random phases with different idle patterns
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct   = gap_pct[phase];
      recv_stall_pct = stall_pct[phase];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (list_len == 0) grow = 1'b1;
        else if (list_len >= ple_pkg::CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
        else if ($urandom_range(49) == 0) grow = !grow;
        send_request(pick_request(list_len, grow));
      end
      // hold off the sender until every awaited result is back
      in_valid <= 1'b0;
      @(negedge clk);
      while (pending != 0) @(negedge clk);
    end

    // let any stray result item show up
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d requests, %0d of them directed, and checked %0d result items",
             sent, directed, checked);
    $display("full list rejects seen: %0d, across three sender and receiver idle patterns",
             full_rejects);
    if (fail_count == 0) begin
      $display("positional_list_engine_test: clean");
    end else begin
      $display("positional_list_engine_test: errors");
    end
    $finish;
  end

endmodule
